// ===== rtl/core/rmfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmfg_pkg
// Shared types, frame constants and the CRC-8 byte update for the ramped
// motor frame generator.
// ----------------------------------------------------------------------------
package rmfg_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RAMP_W  = 31;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] CMD_BYTE  = 8'h31;
	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam logic [7:0] CRC_TOP   = 8'h80;

	localparam logic [RAMP_W-1:0] RAMP_RESET = 31'd50;

	// Write side of the value queue
	typedef struct packed {
		logic               push;
		logic [VALUE_W-1:0] value;
	} rmfg_push_t;

	// Read side of the value queue
	typedef struct packed {
		logic               avail;
		logic [VALUE_W-1:0] value;
	} rmfg_head_t;

	// Fold one byte into a CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/rmfg_front.sv =====
// ----------------------------------------------------------------------------
// rmfg_front
// Accepts tick transactions, applies the slew limit to the kept value and
// pushes the resulting value into the frame queue.
// ----------------------------------------------------------------------------
module rmfg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [rmfg_pkg::RAMP_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rmfg_pkg::VALUE_W-1:0]  target_value,
	input  logic                          stop_request,
	input  logic                          q_full,
	output rmfg_pkg::rmfg_push_t          q_push
);

	logic [rmfg_pkg::RAMP_W-1:0]  ramp_q;
	logic [rmfg_pkg::VALUE_W-1:0] current_q;
	logic [rmfg_pkg::VALUE_W-1:0] next_value;
	logic signed [32:0]           diff;
	logic signed [32:0]           ramp_pos;
	logic signed [32:0]           ramp_neg;
	logic [rmfg_pkg::VALUE_W-1:0] cur_plus;
	logic [rmfg_pkg::VALUE_W-1:0] cur_minus;
	logic                         accept;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	// Hold the ramp step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= rmfg_pkg::RAMP_RESET;
		end else if (cfg_write_en) begin
			ramp_q <= cfg_write_data;
		end
	end

	// Form the 33-bit difference and both stepped values in parallel
	always_comb begin
		diff      = $signed({target_value[31], target_value})
		          - $signed({current_q[31], current_q});
		ramp_pos  = $signed({2'b00, ramp_q});
		ramp_neg  = -ramp_pos;
		cur_plus  = current_q + {1'b0, ramp_q};
		cur_minus = current_q - {1'b0, ramp_q};
		if (stop_request) begin
			next_value = '0;
		end else if (diff > ramp_pos) begin
			next_value = cur_plus;
		end else if (diff < ramp_neg) begin
			next_value = cur_minus;
		end else begin
			next_value = target_value;
		end
	end

	// Advance the kept value on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
		end else if (accept) begin
			current_q <= next_value;
		end
	end

	assign q_push.push  = accept;
	assign q_push.value = next_value;

endmodule

// ===== rtl/core/rmfg_queue.sv =====
// ----------------------------------------------------------------------------
// rmfg_queue
// Two-entry queue of frame values between the tick front and the byte
// serializer.
// ----------------------------------------------------------------------------
module rmfg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmfg_pkg::rmfg_push_t q_push,
	output logic                 q_full,
	input  logic                 q_pop,
	output rmfg_pkg::rmfg_head_t q_head
);

	logic [rmfg_pkg::VALUE_W-1:0] entry_q [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign q_full  = (count_q == 2'd2);
	assign do_push = q_push.push & ~q_full;
	assign do_pop  = q_pop & (count_q != 2'd0);

	// Store pushed values
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_push.value;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_head.avail = (count_q != 2'd0);
	assign q_head.value = entry_q[rd_ptr_q];

endmodule

// ===== rtl/core/rmfg_back.sv =====
// ----------------------------------------------------------------------------
// rmfg_back
// Serializes one queued value into a control frame, one byte per output
// transaction, with a running CRC-8 over command, length and data.
// ----------------------------------------------------------------------------
module rmfg_back #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmfg_pkg::rmfg_head_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           frame_byte,
	output logic                 last_byte
);

	localparam int unsigned DATA_LEN  = 4 * NUM_CHANNELS;
	localparam int unsigned FRAME_LEN = DATA_LEN + 4;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

	localparam logic [IDX_W-1:0] IDX_SYNC = '0;
	localparam logic [IDX_W-1:0] IDX_CMD  = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_LEN  = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_CRC  = IDX_W'(FRAME_LEN - 1);
	localparam logic [7:0]       LEN_BYTE = 8'(DATA_LEN);

	logic [IDX_W-1:0]             idx_q;
	logic [rmfg_pkg::VALUE_W-1:0] val_q;
	logic [7:0]                   crc_q;
	logic                         out_valid_q;
	logic [7:0]                   byte_q;
	logic                         last_q;
	logic                         adv;
	logic                         emit;
	logic [7:0]                   cur_byte;
	logic [7:0]                   data_byte;
	logic [1:0]                   lane;
	logic [IDX_W-1:0]             idx_plus;

	// Output register can take a byte when empty or being drained
	assign adv   = ~out_valid_q | ~out_stall;
	assign q_pop = adv & (idx_q == IDX_SYNC) & q_head.avail;
	assign emit  = adv & ((idx_q != IDX_SYNC) | q_head.avail);

	// Pick the data byte of the current lane, little-endian
	always_comb begin
		idx_plus = idx_q + IDX_W'(1);
		lane     = idx_plus[1:0];
		case (lane)
			2'd0:    data_byte = val_q[7:0];
			2'd1:    data_byte = val_q[15:8];
			2'd2:    data_byte = val_q[23:16];
			default: data_byte = val_q[31:24];
		endcase
	end

	// Select the byte for the current frame position
	always_comb begin
		if (idx_q == IDX_SYNC) begin
			cur_byte = rmfg_pkg::SYNC_BYTE;
		end else if (idx_q == IDX_CMD) begin
			cur_byte = rmfg_pkg::CMD_BYTE;
		end else if (idx_q == IDX_LEN) begin
			cur_byte = LEN_BYTE;
		end else if (idx_q == IDX_CRC) begin
			cur_byte = crc_q;
		end else begin
			cur_byte = data_byte;
		end
	end

	// Load the frame value and advance the running CRC
	always_ff @(posedge clk) begin
		if (q_pop) begin
			val_q <= q_head.value;
			crc_q <= 8'h00;
		end else if (emit && idx_q != IDX_CRC) begin
			crc_q <= rmfg_pkg::crc8_feed(crc_q, cur_byte);
		end
	end

	// Step through the frame positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_SYNC;
		end else if (emit) begin
			idx_q <= (idx_q == IDX_CRC) ? IDX_SYNC : idx_plus;
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= cur_byte;
			last_q <= (idx_q == IDX_CRC);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	// A frame always starts from position zero after its CRC byte
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> idx_q == IDX_SYNC)
		else $error("frame position not rewound after CRC byte");

	// A value is taken from the queue only at the start of a frame
	a_pop_at_sync: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> idx_q == IDX_SYNC && q_head.avail)
		else $error("queue popped mid-frame");

	// Popping a value presents the sync byte next
	a_sync_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q && byte_q == rmfg_pkg::SYNC_BYTE && !last_q)
		else $error("sync byte missing after frame start");

endmodule

// ===== rtl/core/ramped_motor_frame_generator_core.sv =====
// ----------------------------------------------------------------------------
// ramped_motor_frame_generator_core
// Slew-limited value generator that frames each tick as a control message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one tick transaction carries
//   target_value and stop_request. A normal tick moves the kept value toward
//   the target by at most the ramp step; a stop tick clears it.
//   Output channel (out_valid / out_stall): each tick yields a frame of
//   4*NUM_CHANNELS+4 byte transactions (20 at four channels): sync, command,
//   length, the value per channel little-endian, then CRC-8; last_byte marks
//   the CRC byte.
//   Configuration: cfg_write_en with cfg_write_data loads the ramp step;
//   write it only while the block is idle.
//   Timing: the accepted value is registered in the queue, then its sync
//   byte in the output register. The byte serializer emits one byte per
//   cycle while out_stall is low; up to two computed values wait in a
//   queue, so ticks are taken in consecutive cycles until it fills.
//   Reset: kept value is zero, ramp step is 50, queue and output are empty.
//   Output stall: the presented byte holds; the queue fills and then
//   in_stall rises.
// ----------------------------------------------------------------------------
module ramped_motor_frame_generator_core #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [rmfg_pkg::RAMP_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rmfg_pkg::VALUE_W-1:0]  target_value,
	input  logic                          stop_request,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    frame_byte,
	output logic                          last_byte
);

	rmfg_pkg::rmfg_push_t q_push;
	rmfg_pkg::rmfg_head_t q_head;
	logic                 q_full;
	logic                 q_pop;

	rmfg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.target_value   (target_value),
		.stop_request   (stop_request),
		.q_full         (q_full),
		.q_push         (q_push)
	);

	rmfg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_head (q_head)
	);

	rmfg_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
